/* rtl/core/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define LCDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LCDC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/lcdc_pkg.sv */
`default_nettype none

package lcdc_pkg;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_WR   = 2'd1,
    REQ_RD   = 2'd2,
    REQ_STAT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    PEND_NONE      = 2'd0,
    PEND_CONTRAST  = 2'd1,
    PEND_INDICATOR = 2'd2
  } pend_e;

  localparam logic [7:0] MASK_PAIR = 8'hFE;
  localparam logic [7:0] MASK_NIB  = 8'hF0;
  localparam logic [7:0] MASK_TOP2 = 8'hC0;
  localparam logic [7:0] MASK_TOP5 = 8'hF8;

  localparam logic [7:0] CMD_DISPLAY   = 8'hAE;
  localparam logic [7:0] CMD_START     = 8'h40;
  localparam logic [7:0] CMD_CONTRAST  = 8'h81;
  localparam logic [7:0] CMD_PAGE      = 8'hB0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_ADC       = 8'hA0;
  localparam logic [7:0] CMD_REVERSE   = 8'hA6;
  localparam logic [7:0] CMD_ALL_ON    = 8'hA4;
  localparam logic [7:0] CMD_BIAS      = 8'hA2;
  localparam logic [7:0] CMD_SHL       = 8'hC0;
  localparam logic [7:0] CMD_POWER     = 8'h28;
  localparam logic [7:0] CMD_REGULATOR = 8'h20;
  localparam logic [7:0] CMD_INDICATOR = 8'hAC;
  localparam logic [7:0] CMD_RMW       = 8'hE0;
  localparam logic [7:0] CMD_RMW_END   = 8'hEE;
  localparam logic [7:0] CMD_RESET     = 8'hE2;

  typedef struct packed {
    logic       display_on;
    logic [5:0] start_line;
    logic       reverse_video;
    logic       all_pixels_on;
    logic       segment_reverse;
    logic       common_reverse;
    logic       bias_select;
    logic [2:0] power_bits;
    logic [2:0] regulator_ratio;
    logic [5:0] contrast;
    logic [2:0] indicator;
  } settings_t;

  localparam settings_t SETTINGS_RST = '{
    display_on:      1'b0,
    start_line:      6'd0,
    reverse_video:   1'b0,
    all_pixels_on:   1'b0,
    segment_reverse: 1'b0,
    common_reverse:  1'b0,
    bias_select:     1'b0,
    power_bits:      3'd0,
    regulator_ratio: 3'd0,
    contrast:        6'd32,
    indicator:       3'd0
  };

  typedef struct packed {
    logic ram_wr;
    logic ram_rd;
    logic latch_clr;
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/lcdc_intf.sv */
`default_nettype none

interface lcdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] bus_data;

  modport source (output valid, output req_type, output bus_data, input ready);
  modport sink (input valid, input req_type, input bus_data, output ready);
endinterface

interface lcdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       display_on;
  logic [5:0] start_line;
  logic       reverse_video;
  logic       all_pixels_on;
  logic       segment_reverse;
  logic       common_reverse;
  logic       bias_select;
  logic [2:0] power_bits;
  logic [2:0] regulator_ratio;
  logic [5:0] contrast;
  logic [2:0] indicator;

  modport source (
    output valid, output read_value, output display_on, output start_line,
    output reverse_video, output all_pixels_on, output segment_reverse,
    output common_reverse, output bias_select, output power_bits,
    output regulator_ratio, output contrast, output indicator, input ready
  );
  modport sink (
    input valid, input read_value, input display_on, input start_line,
    input reverse_video, input all_pixels_on, input segment_reverse,
    input common_reverse, input bias_select, input power_bits,
    input regulator_ratio, input contrast, input indicator, output ready
  );
endinterface

`default_nettype wire

/* rtl/core/lcdc_ram.sv */
`default_nettype none

module lcdc_ram #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [7:0]               wdata_i,
  output      logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/lcdc_regs.sv */
`default_nettype none

module lcdc_regs #(
  parameter int unsigned PAGES   = 8,
  parameter int unsigned COLUMNS = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [1:0]                           req_type_i,
  input  wire logic [7:0]                           bus_data_i,
  output      lcdc_pkg::settings_t                  settings_o,
  output      lcdc_pkg::settings_t                  settings_nxt_o,
  output      lcdc_pkg::ctl_t                       ctl_o,
  output      logic [$clog2(PAGES*COLUMNS)-1:0]     addr_o
);

  import lcdc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AddrW = $clog2(PAGES*COLUMNS);

  settings_t   set_q, set_d;
  logic [3:0]  page_q, page_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  saved_q, saved_d;
  logic        mod_q, mod_d;
  pend_e       pend_q, pend_d;
  logic [3:0]  page_eff;
  logic [7:0]  col_eff;
  logic        col_last;
  logic [7:0]  b;

  assign b = bus_data_i;

  // out-of-range addresses act as the last page or column
  assign page_eff = ({1'b0, page_q} >= 5'(PAGES)) ? 4'(PAGES - 1) : page_q;
  assign col_eff  = ({1'b0, col_q} >= 9'(COLUMNS)) ? 8'(COLUMNS - 1) : col_q;
  assign col_last = {1'b0, col_q} >= 9'(COLUMNS - 1);
  assign addr_o   = AddrW'(32'(page_eff) * 32'(COLUMNS) + 32'(col_eff));

  always_comb begin
    set_d   = set_q;
    page_d  = page_q;
    col_d   = col_q;
    saved_d = saved_q;
    mod_d   = mod_q;
    pend_d  = pend_q;
    ctl_o   = '0;
    if (step_i) begin
      case (req_type_i)
        REQ_CMD: begin
          if (pend_q == PEND_CONTRAST) begin
            set_d.contrast = b[5:0];
            pend_d = PEND_NONE;
          end else if (pend_q != PEND_NONE) begin
            set_d.indicator = {set_q.indicator[2], b[1:0]};
            pend_d = PEND_NONE;
          end else if ((b & MASK_PAIR) == CMD_DISPLAY) begin
            set_d.display_on = b[0];
          end else if ((b & MASK_TOP2) == CMD_START) begin
            set_d.start_line = b[5:0];
          end else if (b == CMD_CONTRAST) begin
            pend_d = PEND_CONTRAST;
          end else if ((b & MASK_NIB) == CMD_PAGE) begin
            page_d = b[3:0];
          end else if ((b & MASK_NIB) == CMD_COL_HI) begin
            col_d = {b[3:0], col_q[3:0]};
          end else if ((b & MASK_NIB) == CMD_COL_LO) begin
            col_d = {col_q[7:4], b[3:0]};
          end else if ((b & MASK_PAIR) == CMD_ADC) begin
            set_d.segment_reverse = b[0];
          end else if ((b & MASK_PAIR) == CMD_REVERSE) begin
            set_d.reverse_video = b[0];
          end else if ((b & MASK_PAIR) == CMD_ALL_ON) begin
            set_d.all_pixels_on = b[0];
          end else if ((b & MASK_PAIR) == CMD_BIAS) begin
            set_d.bias_select = b[0];
          end else if ((b & MASK_NIB) == CMD_SHL) begin
            set_d.common_reverse = b[3];
          end else if ((b & MASK_TOP5) == CMD_POWER) begin
            set_d.power_bits = b[2:0];
          end else if ((b & MASK_TOP5) == CMD_REGULATOR) begin
            set_d.regulator_ratio = b[2:0];
          end else if ((b & MASK_PAIR) == CMD_INDICATOR) begin
            set_d.indicator = {b[0], set_q.indicator[1:0]};
            pend_d = PEND_INDICATOR;
          end else if (b == CMD_RMW) begin
            mod_d   = 1'b1;
            saved_d = col_q;
          end else if (b == CMD_RMW_END) begin
            mod_d = 1'b0;
            col_d = saved_q;
          end else if (b == CMD_RESET) begin
            set_d   = SETTINGS_RST;
            page_d  = '0;
            col_d   = '0;
            saved_d = '0;
            mod_d   = 1'b0;
            pend_d  = PEND_NONE;
            ctl_o.latch_clr = 1'b1;
          end
        end
        REQ_WR: begin
          ctl_o.ram_wr = 1'b1;
          if (!col_last) begin
            col_d = col_q + 8'd1;
          end
        end
        REQ_RD: begin
          ctl_o.ram_rd = 1'b1;
          if (!mod_q && !col_last) begin
            col_d = col_q + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q   <= SETTINGS_RST;
      page_q  <= '0;
      col_q   <= '0;
      saved_q <= '0;
      mod_q   <= 1'b0;
      pend_q  <= PEND_NONE;
    end else begin
      set_q   <= set_d;
      page_q  <= page_d;
      col_q   <= col_d;
      saved_q <= saved_d;
      mod_q   <= mod_d;
      pend_q  <= pend_d;
    end
  end

  assign settings_o     = set_q;
  assign settings_nxt_o = set_d;

  `LCDC_ASSERT(a_pend_once, clk_i, rst_ni, (step_i && req_type_i == REQ_CMD && pend_q != PEND_NONE) |=> (pend_q == PEND_NONE), "operand byte left a command pending")
  `LCDC_ASSERT(a_rmw_hold, clk_i, rst_ni, (step_i && req_type_i == REQ_RD && mod_q) |=> $stable(col_q), "column moved on a read in modify-read")
  `LCDC_ASSERT(a_col_sat, clk_i, rst_ni, (step_i && req_type_i == REQ_WR && col_last) |=> $stable(col_q), "column moved past the last column")

endmodule

`default_nettype wire

/* rtl/core/lcd_controller_ddram_interface.sv */
// channel  dir  handshake    payload
// in_i     in   valid/ready  req_type, bus_data
// out_o    out  valid/ready  read_value and the current display settings
//
// one item per cycle while out_o is taken; one result item per input item
// a data read returns the output latch, which is the display ram read data
// register loaded by the previous data read; the ram has one port
// reset clears the address and settings registers, not the display ram
// in_i.ready falls only while a result item waits in the output register

`default_nettype none

module lcd_controller_ddram_interface #(
  parameter int unsigned PAGES   = 8,
  parameter int unsigned COLUMNS = 128
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lcdc_in_if.sink   in_i,
  lcdc_out_if.source out_o
);

  import lcdc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned Depth = PAGES * COLUMNS;
  localparam int unsigned AddrW = $clog2(Depth);

  logic             in_acc;
  settings_t        set_cur, set_nxt, set_out_q;
  ctl_t             ctl;
  logic [AddrW-1:0] addr;
  logic [7:0]       rdata;
  logic [7:0]       latch_val;
  logic [7:0]       rv_d, rv_q;
  logic             latch_ram_q, latch_ram_d;
  logic             out_valid_q, out_valid_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  lcdc_regs #(
    .PAGES  (PAGES),
    .COLUMNS(COLUMNS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_acc),
    .req_type_i    (in_i.req_type),
    .bus_data_i    (in_i.bus_data),
    .settings_o    (set_cur),
    .settings_nxt_o(set_nxt),
    .ctl_o         (ctl),
    .addr_o        (addr)
  );

  lcdc_ram #(
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl.ram_wr),
    .re_i   (ctl.ram_rd),
    .addr_i (addr),
    .wdata_i(in_i.bus_data),
    .rdata_o(rdata)
  );

  assign latch_val = latch_ram_q ? rdata : 8'd0;

  always_comb begin
    case (in_i.req_type)
      REQ_RD:   rv_d = latch_val;
      REQ_STAT: rv_d = {1'b0, set_cur.segment_reverse, ~set_cur.display_on, 5'd0};
      default:  rv_d = 8'd0;
    endcase
  end

  always_comb begin
    latch_ram_d = latch_ram_q;
    if (ctl.latch_clr) begin
      latch_ram_d = 1'b0;
    end else if (ctl.ram_rd) begin
      latch_ram_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      latch_ram_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      latch_ram_q <= latch_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rv_q      <= rv_d;
      set_out_q <= set_nxt;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_value      = rv_q;
  assign out_o.display_on      = set_out_q.display_on;
  assign out_o.start_line      = set_out_q.start_line;
  assign out_o.reverse_video   = set_out_q.reverse_video;
  assign out_o.all_pixels_on   = set_out_q.all_pixels_on;
  assign out_o.segment_reverse = set_out_q.segment_reverse;
  assign out_o.common_reverse  = set_out_q.common_reverse;
  assign out_o.bias_select     = set_out_q.bias_select;
  assign out_o.power_bits      = set_out_q.power_bits;
  assign out_o.regulator_ratio = set_out_q.regulator_ratio;
  assign out_o.contrast        = set_out_q.contrast;
  assign out_o.indicator       = set_out_q.indicator;

  `LCDC_NEVER(a_ram_one_op, clk_i, rst_ni, ctl.ram_wr && ctl.ram_rd, "ram read and write in one cycle")
  `LCDC_NEVER(a_ram_on_acc, clk_i, rst_ni, (ctl.ram_wr || ctl.ram_rd) && !in_acc, "ram access without an item")
  `LCDC_ASSERT(a_latch_load, clk_i, rst_ni, (in_acc && in_i.req_type == REQ_RD) |=> latch_ram_q, "output latch not reloaded by a data read")

endmodule

`default_nettype wire
